FILE: hdl/awgn_pkg.sv
// Package for the AWGN channel noise adder: word types, register indexes,
// generator constants and the back-end state type. No dependencies.
package awgn_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LCG_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SIGMA = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MEAN  = 2'd1;

    localparam logic [CFG_W-1:0] SIGMA_RESET = 16'd4096;
    localparam logic [CFG_W-1:0] MEAN_RESET  = 16'd0;

    // x' = x * 2053 + 13849 mod 2^16
    localparam logic [LCG_W-1:0] LCG_MUL = 16'd2053;
    localparam logic [LCG_W-1:0] LCG_ADD = 16'd13849;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] tx_sample;
        logic                       frame_start;
        logic        [LCG_W-1:0]    frame_seed;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] noisy_sample;
        logic                       clipped;
    } out_word_t;

    typedef enum logic {
        OP_CONTINUE = 1'b0,
        OP_RELOAD   = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                    op;
        logic        [LCG_W-1:0]    seed;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MUL,
        ST_ADD
    } back_state_t;

endpackage

FILE: hdl/awgn_channel_noise_adder_top.sv
// Top level of the AWGN channel noise adder: configuration registers,
// front-end queue and back-end noise datapath. Depends on awgn_pkg,
// awgn_front and awgn_back.
//
// Each input word gets one Gaussian-like noise value added: a 16-bit LCG
// (x' = x*2053 + 13849 mod 2^16) is stepped UNIFORM_COUNT times, the values
// are summed and centred, scaled by noise_sigma / 2^16 (round half up),
// offset by noise_mean, added to tx_sample and saturated to 16 bits, with
// clipped set when saturation happened. frame_start reloads the generator
// from frame_seed before that word. The back end runs one LCG step per
// cycle through a single constant multiplier, forms the product in ST_MUL,
// then adds, saturates and loads the output register in ST_ADD; it takes no
// new word until the result is loaded. A two-word queue in front and an
// output register behind let the input and result sides stall
// independently. Register 0 is noise_sigma (unsigned Q4.12, reset
// 4096), register 1 is noise_mean (signed Q4.12, reset 0); only the low 16
// bits of cfg_data are kept and other indexes are ignored. Write registers
// only while no word is in flight. The generator resets to zero.
module awgn_channel_noise_adder_top import awgn_pkg::*; #(
    parameter int UNIFORM_COUNT = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input word channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    // result word channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        [CFG_W-1:0] sigma_reg, sigma_next;
    logic signed [CFG_W-1:0] mean_reg, mean_next;

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Writes are always accepted
    assign cfg_ready = 1'b1;

    always_comb begin
        sigma_next = sigma_reg;
        mean_next  = mean_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_SIGMA: sigma_next = cfg_data[CFG_W-1:0];
                CFG_IDX_MEAN:  mean_next  = cfg_data[CFG_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= SIGMA_RESET;
            mean_reg  <= MEAN_RESET;
        end else begin
            sigma_reg <= sigma_next;
            mean_reg  <= mean_next;
        end
    end

    // Front: accept and classify, buffer two words
    awgn_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    // Back: generator, scaling, saturation, result register
    awgn_back #(
        .UNIFORM_COUNT (UNIFORM_COUNT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd),
        .noise_sigma (sigma_reg),
        .noise_mean  (mean_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: hdl/awgn_front.sv
// Front end: accepts input words, classifies them as reload or continue
// and holds them in a two-entry queue. Depends on awgn_pkg.
module awgn_front import awgn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output cmd_t     q_cmd
);

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       cmd_in;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cmd_in.op     = s_data.frame_start ? OP_RELOAD : OP_CONTINUE;
        cmd_in.seed   = s_data.frame_seed;
        cmd_in.sample = s_data.tx_sample;
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next      = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_fill_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) || (cnt_reg == 2'd1) || (cnt_reg == 2'd2))
        else $error("front queue level out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("front queue pointers disagree with level");
`endif

endmodule

FILE: hdl/awgn_back.sv
// Back end: steps the LCG once a cycle, sums the uniforms, scales by sigma,
// adds mean and sample, saturates and holds the result word. Depends on awgn_pkg.
module awgn_back import awgn_pkg::*; #(
    parameter int UNIFORM_COUNT = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  cmd_t                     q_cmd,
    input  logic        [CFG_W-1:0]  noise_sigma,
    input  logic signed [CFG_W-1:0]  noise_mean,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_word_t                m_data
);

    localparam int SUM_W  = LCG_W + $clog2(UNIFORM_COUNT);
    localparam int CNT_W  = (UNIFORM_COUNT > 1) ? $clog2(UNIFORM_COUNT) : 1;
    localparam int PROD_W = SUM_W + 1 + CFG_W + 1;
    localparam int NZ_W   = PROD_W - 16;
    localparam int TOT_W  = SUM_W + 4;

    localparam logic [CNT_W-1:0]         CNT_LAST = CNT_W'(UNIFORM_COUNT - 1);
    localparam logic signed [SUM_W:0]    CENTER   = (SUM_W+1)'(UNIFORM_COUNT * 32768);
    localparam logic signed [PROD_W-1:0] ROUND    = PROD_W'(32768);
    localparam logic signed [TOT_W-1:0]  SAT_HI   = TOT_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [TOT_W-1:0]  SAT_LO   = -SAT_HI - TOT_W'(1);

    back_state_t                state_reg, state_next;
    logic        [LCG_W-1:0]    lcg_reg, lcg_next;
    logic        [SUM_W-1:0]    sum_reg, sum_next;
    logic        [CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       out_valid_reg, out_valid_next;
    out_word_t                  out_data_reg, out_data_next;

    logic        [LCG_W-1:0]    lcg_step;
    logic signed [SUM_W:0]      centred;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [NZ_W-1:0]     noise;
    logic signed [TOT_W-1:0]    total;

    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign lcg_step = lcg_reg * LCG_MUL + LCG_ADD;
    assign centred  = $signed({1'b0, sum_reg}) - CENTER;
    assign rounded  = prod_reg + ROUND;
    assign noise    = rounded[PROD_W-1:16];   // floor divide by 2^16
    assign total    = TOT_W'(sample_reg) + TOT_W'(noise_mean) + TOT_W'(noise);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lcg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        sample_reg   <= sample_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        lcg_next       = lcg_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        sample_next    = sample_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        q_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    lcg_next    = (q_cmd.op == OP_RELOAD) ? q_cmd.seed : lcg_reg;
                    sample_next = q_cmd.sample;
                    sum_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                lcg_next = lcg_step;
                sum_next = sum_reg + SUM_W'(lcg_step);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(centred) * PROD_W'($signed({1'b0, noise_sigma}));
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    priority if (total > SAT_HI) begin
                        out_data_next.noisy_sample = SAT_HI[SAMPLE_W-1:0];
                        out_data_next.clipped      = 1'b1;
                    end else if (total < SAT_LO) begin
                        out_data_next.noisy_sample = SAT_LO[SAMPLE_W-1:0];
                        out_data_next.clipped      = 1'b1;
                    end else begin
                        out_data_next.noisy_sample = total[SAMPLE_W-1:0];
                        out_data_next.clipped      = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_LAST))
        else $error("generator step count overran");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD && (!out_valid_reg || m_ready)) |=> m_valid)
        else $error("finished result not presented");
`endif

endmodule
